>>> sv/sli_pkg.sv
// ----------------------------------------------------------------------------
// sli_pkg
// Shared types and codes for the sorted list insert/delete block.
// ----------------------------------------------------------------------------
package sli_pkg;

  localparam int CapacityDef = 16;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DELETED   = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  typedef struct packed {
    logic       command;
    logic [7:0] value;
  } sli_cmd_t;

  typedef struct packed {
    logic [2:0] status;
    logic [4:0] entry_count;
    logic [7:0] smallest_value;
  } sli_res_t;

  typedef struct packed {
    logic       ins_en;
    logic       del_en;
    logic [7:0] value;
  } sli_ctl_t;

endpackage

>>> sv/sli_cell.sv
// ----------------------------------------------------------------------------
// sli_cell
// One list slot: holds an entry and its valid bit, compares against the
// command value and shifts right on insert or left on delete.
// ----------------------------------------------------------------------------
module sli_cell
  import sli_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  sli_ctl_t   ctl_i,
  input  logic       left_gt_i,
  input  logic [7:0] left_data_i,
  input  logic       left_valid_i,
  input  logic [7:0] right_data_i,
  input  logic       right_valid_i,
  output logic [7:0] data_o,
  output logic       valid_o,
  output logic       gt_o,
  output logic       eq_o
);

  logic [7:0] data_q, data_d;
  logic       valid_q, valid_d;
  logic       lt;

  assign gt_o    = valid_q && (ctl_i.value > data_q);
  assign eq_o    = valid_q && (ctl_i.value == data_q);
  assign lt      = valid_q && (data_q < ctl_i.value);
  assign data_o  = data_q;
  assign valid_o = valid_q;

  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    if (ctl_i.ins_en && !gt_o) begin
      if (left_gt_i) begin
        data_d  = ctl_i.value;
        valid_d = 1'b1;
      end else begin
        data_d  = left_data_i;
        valid_d = left_valid_i;
      end
    end else if (ctl_i.del_en && !lt) begin
      data_d  = right_data_i;
      valid_d = right_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

>>> sv/sorted_list_insert_delete.sv
// ----------------------------------------------------------------------------
// sorted_list_insert_delete
// Ascending sorted byte list held in a chain of compare-and-shift cells.
//
//   channel   handshake              payload
//   command   start / busy           cmd_i   (command, value)
//   result    res_strobe_o           res_o   (status, entry_count, smallest)
//
// All cells compare and shift in parallel at the accepting edge, and the
// result is shown in the following cycle.
// busy stays low, so a command may be given in every cycle.
// Reset clears every valid bit and the count; entries need no clearing.
// The result strobe lasts one cycle and the receiver cannot stall it.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete
  import sli_pkg::*;
#(
  parameter int CAPACITY = CapacityDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  sli_cmd_t cmd_i,
  output logic     res_strobe_o,
  output sli_res_t res_o
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0] count_q, count_d;
  logic [2:0]    status_q, status_d;
  logic          strobe_q;
  logic          accept, found, empty, full;
  sli_ctl_t      ctl;

  logic [CAPACITY-1:0]      valid_v, gt_v, eq_v;
  logic [CAPACITY-1:0][7:0] data_v;
  logic [CW+4:0]            count_ext;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign found  = |eq_v;
  assign empty  = (count_q == '0);
  assign full   = (count_q == CW'(CAPACITY));

  always_comb begin
    ctl.value  = cmd_i.value;
    ctl.ins_en = accept && (cmd_i.command == CMD_INSERT) && !full;
    ctl.del_en = accept && (cmd_i.command == CMD_DELETE) && found;
  end

  always_comb begin
    count_d  = count_q;
    status_d = status_q;
    if (accept) begin
      if (cmd_i.command == CMD_INSERT) begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          status_d = ST_INSERTED;
          count_d  = count_q + CW'(1);
        end
      end else if (empty) begin
        status_d = ST_EMPTY;
      end else if (found) begin
        status_d = ST_DELETED;
        count_d  = count_q - CW'(1);
      end else begin
        status_d = ST_NOT_FOUND;
      end
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic       l_gt, l_valid, r_valid;
    logic [7:0] l_data, r_data;
    if (i == 0) begin : g_head
      assign l_gt    = 1'b1;
      assign l_data  = cmd_i.value;
      assign l_valid = 1'b1;
    end else begin : g_body
      assign l_gt    = gt_v[i-1];
      assign l_data  = data_v[i-1];
      assign l_valid = valid_v[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign r_data  = 8'd0;
      assign r_valid = 1'b0;
    end else begin : g_next
      assign r_data  = data_v[i+1];
      assign r_valid = valid_v[i+1];
    end
    sli_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .left_gt_i    (l_gt),
      .left_data_i  (l_data),
      .left_valid_i (l_valid),
      .right_data_i (r_data),
      .right_valid_i(r_valid),
      .data_o       (data_v[i]),
      .valid_o      (valid_v[i]),
      .gt_o         (gt_v[i]),
      .eq_o         (eq_v[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      strobe_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      strobe_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
  end

  assign count_ext = {5'd0, count_q};

  assign res_strobe_o         = strobe_q;
  assign res_o.status         = status_q;
  assign res_o.entry_count    = count_ext[4:0];
  assign res_o.smallest_value = valid_v[0] ? data_v[0] : 8'd0;

  a_strobe_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> res_strobe_o)
    else $error("result strobe missing after accepted beat");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !res_strobe_o)
    else $error("result strobe without accepted beat");

  a_valid_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_v) == int'(count_q))
    else $error("valid bits disagree with entry count");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && res_o.status == ST_INSERTED) |->
      count_q == $past(count_q) + CW'(1))
    else $error("insert did not advance count");

endmodule

>>> verif/sorted_list_insert_delete_tb.sv
// ----------------------------------------------------------------------------
// sorted_list_insert_delete_tb
// Self-checking bench for the sorted byte list. A short table covers the
// empty list, zero and 0xFF values, duplicates, filling to capacity and the
// full rejection. Random inserts and deletes follow, in phases that lean
// toward filling or draining so that both ends are reached again and again.
// Every result is compared field by field against a queue-based model of the
// list or the table's fixed result, with random gaps between commands.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete_tb;
  import sli_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int Capacity  = CapacityDef;
  localparam int ClkPeriod = 12;
  localparam int RandItems = 1025;
  localparam int DrainMax  = 2000;

  typedef struct {
    sli_cmd_t op;
    bit       fixed;
    sli_res_t res;
  } dir_row_t;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     start;
  logic     busy;
  sli_cmd_t cmd_i;
  logic     res_strobe_o;
  sli_res_t res_o;

  logic [7:0] list_model_q[$];
  sli_res_t   outcome_q[$];
  dir_row_t   dir_rows_q[$];
  int         err_count;
  int         beats_sent;
  int         results_seen;
  int         status_seen[5];

  sorted_list_insert_delete #(
    .CAPACITY(Capacity)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .res_strobe_o(res_strobe_o),
    .res_o       (res_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  function automatic sli_res_t list_op_outcome(input sli_cmd_t op);
    sli_res_t r;
    int       pos;
    pos = 0;
    if (op.command == CMD_INSERT) begin
      if (list_model_q.size() >= Capacity) begin
        r.status = ST_FULL;
      end else begin
        while (pos < list_model_q.size() && op.value > list_model_q[pos]) pos++;
        list_model_q.insert(pos, op.value);
        r.status = ST_INSERTED;
      end
    end else if (list_model_q.size() == 0) begin
      r.status = ST_EMPTY;
    end else begin
      while (pos < list_model_q.size() && list_model_q[pos] != op.value) pos++;
      if (pos >= list_model_q.size()) begin
        r.status = ST_NOT_FOUND;
      end else begin
        list_model_q.delete(pos);
        r.status = ST_DELETED;
      end
    end
    r.entry_count    = 5'(list_model_q.size());
    r.smallest_value = (list_model_q.size() > 0) ? list_model_q[0] : 8'h00;
    return r;
  endfunction

  function automatic logic [7:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (list_model_q.size() > 0 && r < 55)
      return list_model_q[$urandom_range(0, list_model_q.size() - 1)];
    if (r < 65) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  function automatic int pick_gap(input bit no_idle);
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void add_row(input logic cmd, input logic [7:0] val, input bit fixed,
                                  input logic [2:0] st, input logic [4:0] cnt,
                                  input logic [7:0] head);
    dir_row_t row;
    row.op.command         = cmd;
    row.op.value           = val;
    row.fixed              = fixed;
    row.res.status         = st;
    row.res.entry_count    = cnt;
    row.res.smallest_value = head;
    dir_rows_q.push_back(row);
  endfunction

  // hold start until the beat is taken, then log its outcome
  task automatic issue_op(input sli_cmd_t op, input bit fixed, input sli_res_t fixed_res,
                          input bit no_idle);
    sli_res_t pred;
    int       gap;
    start <= 1'b1;
    cmd_i <= op;
    do @(posedge clk_i); while (busy);
    pred = list_op_outcome(op);
    outcome_q.push_back(fixed ? fixed_res : pred);
    beats_sent++;
    gap = pick_gap(no_idle);
    if (gap > 0) begin
      start <= 1'b0;
      cmd_i <= sli_cmd_t'($urandom);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    sli_res_t want;
    if (rst_ni && res_strobe_o) begin
      results_seen++;
      if (res_o.status < 5) status_seen[res_o.status]++;
      if (outcome_q.size() == 0) begin
        $error("result beat with nothing outstanding: %p", res_o);
        err_count++;
      end else begin
        want = outcome_q.pop_front();
        if (res_o.status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, res_o.status);
          err_count++;
        end
        if (res_o.entry_count !== want.entry_count) begin
          $error("entry_count mismatch: expected %0d, actual %0d",
                 want.entry_count, res_o.entry_count);
          err_count++;
        end
        if (res_o.smallest_value !== want.smallest_value) begin
          $error("smallest_value mismatch: expected 0x%02h, actual 0x%02h",
                 want.smallest_value, res_o.smallest_value);
          err_count++;
        end
      end
    end
  end

  initial begin
    sli_cmd_t op;
    int       ins_pct;
    bit       no_idle;
    int       waited;
    start  <= 1'b0;
    cmd_i  <= '0;
    rst_ni <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(CMD_DELETE, 8'h00, 1, ST_EMPTY,     5'd0, 8'h00);
    add_row(CMD_INSERT, 8'hFF, 1, ST_INSERTED,  5'd1, 8'hFF);
    add_row(CMD_INSERT, 8'h00, 1, ST_INSERTED,  5'd2, 8'h00);
    add_row(CMD_DELETE, 8'h00, 1, ST_DELETED,   5'd1, 8'hFF);
    add_row(CMD_DELETE, 8'h80, 1, ST_NOT_FOUND, 5'd1, 8'hFF);
    add_row(CMD_DELETE, 8'hFF, 1, ST_DELETED,   5'd0, 8'h00);
    add_row(CMD_INSERT, 8'h55, 0, '0, '0, '0);
    add_row(CMD_INSERT, 8'hAA, 0, '0, '0, '0);
    add_row(CMD_INSERT, 8'h55, 0, '0, '0, '0);
    add_row(CMD_INSERT, 8'h01, 0, '0, '0, '0);
    add_row(CMD_INSERT, 8'hFE, 0, '0, '0, '0);
    add_row(CMD_INSERT, 8'h7F, 0, '0, '0, '0);
    add_row(CMD_INSERT, 8'h80, 0, '0, '0, '0);
    add_row(CMD_INSERT, 8'h00, 0, '0, '0, '0);
    add_row(CMD_INSERT, 8'h00, 0, '0, '0, '0);
    add_row(CMD_INSERT, 8'hFF, 0, '0, '0, '0);
    add_row(CMD_INSERT, 8'hFF, 0, '0, '0, '0);
    add_row(CMD_INSERT, 8'h33, 0, '0, '0, '0);
    add_row(CMD_INSERT, 8'hCC, 0, '0, '0, '0);
    add_row(CMD_INSERT, 8'h0F, 0, '0, '0, '0);
    add_row(CMD_INSERT, 8'hF0, 0, '0, '0, '0);
    add_row(CMD_INSERT, 8'h10, 0, '0, '0, '0);
    add_row(CMD_INSERT, 8'h42, 1, ST_FULL,      5'd16, 8'h00);
    add_row(CMD_DELETE, 8'h55, 0, '0, '0, '0);
    add_row(CMD_DELETE, 8'h00, 0, '0, '0, '0);

    foreach (dir_rows_q[i])
      issue_op(dir_rows_q[i].op, dir_rows_q[i].fixed, dir_rows_q[i].res, 1'b0);

    ins_pct = 50;
    no_idle = 1'b0;
    for (int n = 0; n < RandItems; n++) begin
      if (n % 48 == 0) begin
        case ($urandom_range(0, 3))
          0:       ins_pct = 10;
          1:       ins_pct = 90;
          2:       ins_pct = 65;
          default: ins_pct = 45;
        endcase
        no_idle = ($urandom_range(0, 3) == 0);
      end
      op.command = ($urandom_range(0, 99) < ins_pct) ? CMD_INSERT : CMD_DELETE;
      op.value   = pick_value();
      issue_op(op, 1'b0, '0, no_idle);
    end
    start <= 1'b0;

    waited = 0;
    while (outcome_q.size() != 0 && waited < DrainMax) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(posedge clk_i);
    if (outcome_q.size() != 0) begin
      $error("%0d results never arrived", outcome_q.size());
      err_count++;
    end

    $display("Sent %0d commands (%0d from the table), checked %0d results.",
             beats_sent, dir_rows_q.size(), results_seen);
    $display("Outcomes: %0d inserted, %0d deleted, %0d not found, %0d full, %0d empty.",
             status_seen[ST_INSERTED], status_seen[ST_DELETED], status_seen[ST_NOT_FOUND],
             status_seen[ST_FULL], status_seen[ST_EMPTY]);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

>>> sorted_list_insert_delete.f
sv/sli_pkg.sv
sv/sli_cell.sv
sv/sorted_list_insert_delete.sv
verif/sorted_list_insert_delete_tb.sv
